### hw/rtl/dib_pkg.sv
// Package for the draw instance batcher: sizes, field widths, codes and types.
`timescale 1ns / 1ps

package dib_pkg;

  localparam int unsigned MAX_INSTANCES = 32;
  localparam int unsigned LEVEL_COUNT   = 16;

  localparam int unsigned IDX_W   = $clog2(MAX_INSTANCES);
  localparam int unsigned CNT_W   = $clog2(MAX_INSTANCES + 1);
  localparam int unsigned LVL_W   = 4;
  localparam int unsigned FN_W    = 16;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned REQ_W   = 8;
  localparam int unsigned OFS_W   = 32;
  localparam int unsigned HND_W   = 32;
  localparam int unsigned OIDX_W  = 5;
  localparam int unsigned OCNT_W  = 6;

  localparam int unsigned S_DATA_W = 120;
  localparam int unsigned M_DATA_W = 96;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 1'd1;

  localparam logic [LVL_W-1:0] LVL_TOP       = LVL_W'(LEVEL_COUNT - 1);
  localparam logic [LVL_W-1:0] MIN_LVL_RESET = '0;
  localparam logic [LVL_W-1:0] MAX_LVL_RESET = 4'd15;
  localparam logic [CNT_W-1:0] CNT_FULL      = CNT_W'(MAX_INSTANCES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CACHE,
    ST_RD,
    ST_EMIT
  } state_e;

endpackage

### hw/rtl/draw_instance_batcher.sv
// Draw instance batcher: merges compatible draw words into instanced batches.
// Timing: a word is cached in the cycle after acceptance; output stalls hold the emit state.
// A flush passes evaluate, read and emit states before registering its first instance word.
// Flow: a new word is taken only after the previous one is cached or flushed; each emitted
// instance adds a buffer read and output register, a flush before caching a cache state.
// Reset: asynchronous, active low; clears count, last-item state and config, not the buffer.
`timescale 1ns / 1ps

module draw_instance_batcher
  import dib_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // draw_fn_id, merge_key, req_level, scene_offset, user_handle
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_fn_id, out_level, batch_count, inst_index, out_offset, out_handle, zero pad
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  // batch_last
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  state_e state_q, state_d;

  logic [LVL_W-1:0] min_lvl_q, max_lvl_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [FN_W-1:0]  last_fn_q, last_fn_d;
  logic [KEY_W-1:0] last_key_q, last_key_d;
  logic [LVL_W-1:0] last_lvl_q, last_lvl_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             flush_b_q, flush_b_d;
  logic             out_vld_q, out_vld_d;

  logic [FN_W-1:0]  it_fn_q;
  logic [KEY_W-1:0] it_key_q;
  logic [LVL_W-1:0] it_lvl_q;
  logic [OFS_W-1:0] it_ofs_q;
  logic [HND_W-1:0] it_hnd_q;
  logic             it_end_q;

  logic [OFS_W-1:0] rd_ofs_q;
  logic [HND_W-1:0] rd_hnd_q;
  logic [M_DATA_W-1:0] out_data_q;
  logic             out_blast_q, out_rlast_q;

  logic [OFS_W-1:0] ofs_mem [MAX_INSTANCES];
  logic [HND_W-1:0] hnd_mem [MAX_INSTANCES];

  logic [REQ_W-1:0] req;
  logic [LVL_W-1:0] clamp_lvl;
  logic             accept, flush_a, do_cache, rd_en, emit, at_last;
  logic [OIDX_W-1:0] out_idx;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign req    = s_axis_tdata[55:48];

  always_comb begin
    clamp_lvl = req[LVL_W-1:0];
    if (req < {4'd0, min_lvl_q}) begin
      clamp_lvl = min_lvl_q;
    end else if (req > {4'd0, max_lvl_q}) begin
      clamp_lvl = max_lvl_q;
    end
    if (clamp_lvl > LVL_TOP) begin
      clamp_lvl = LVL_TOP;
    end
  end

  // flush the pending batch before caching: full, pending key zero, or incompatible word
  assign flush_a = (cnt_q == CNT_FULL) ||
                   ((cnt_q != '0) && ((last_fn_q != it_fn_q) || (last_key_q == '0) ||
                                      (last_key_q != it_key_q) || (last_lvl_q != it_lvl_q)));

  assign at_last = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_EVAL;
      ST_EVAL:  begin
        if (flush_a) state_d = ST_RD;
        else if (it_end_q) state_d = ST_RD;
        else state_d = ST_IDLE;
      end
      ST_CACHE: state_d = it_end_q ? ST_RD : ST_IDLE;
      ST_RD:    state_d = ST_EMIT;
      ST_EMIT:  begin
        if (emit) begin
          if (!at_last) state_d = ST_RD;
          else if (flush_b_q) state_d = ST_IDLE;
          else state_d = ST_CACHE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    do_cache      = 1'b0;
    rd_en         = 1'b0;
    emit          = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_EVAL:  do_cache = !flush_a;
      ST_CACHE: do_cache = 1'b1;
      ST_RD:    rd_en = 1'b1;
      ST_EMIT:  emit = !out_vld_q || m_axis_tready;
      default:  ;
    endcase
  end

  always_comb begin
    cnt_d      = cnt_q;
    last_fn_d  = last_fn_q;
    last_key_d = last_key_q;
    last_lvl_d = last_lvl_q;
    idx_d      = idx_q;
    flush_b_d  = flush_b_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    if (state_q == ST_EVAL && flush_a) begin
      idx_d     = '0;
      flush_b_d = 1'b0;
    end
    if (do_cache) begin
      cnt_d      = cnt_q + CNT_W'(1);
      last_fn_d  = it_fn_q;
      last_key_d = it_key_q;
      last_lvl_d = it_lvl_q;
      idx_d      = '0;
      flush_b_d  = 1'b1;
    end
    if (emit) begin
      out_vld_d = 1'b1;
      if (at_last) begin
        cnt_d = '0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      min_lvl_q  <= MIN_LVL_RESET;
      max_lvl_q  <= MAX_LVL_RESET;
      cnt_q      <= '0;
      last_fn_q  <= '0;
      last_key_q <= '0;
      last_lvl_q <= '0;
      idx_q      <= '0;
      flush_b_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      last_fn_q  <= last_fn_d;
      last_key_q <= last_key_d;
      last_lvl_q <= last_lvl_d;
      idx_q      <= idx_d;
      flush_b_q  <= flush_b_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_LEVEL: min_lvl_q <= cfg_data_i;
          CFG_MAX_LEVEL: max_lvl_q <= cfg_data_i;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_fn_q  <= s_axis_tdata[15:0];
      it_key_q <= s_axis_tdata[47:16];
      it_lvl_q <= clamp_lvl;
      it_ofs_q <= s_axis_tdata[87:56];
      it_hnd_q <= s_axis_tdata[119:88];
      it_end_q <= s_axis_tlast;
    end
  end

  // instance buffer: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (do_cache) begin
      ofs_mem[cnt_q[IDX_W-1:0]] <= it_ofs_q;
      hnd_mem[cnt_q[IDX_W-1:0]] <= it_hnd_q;
    end
    if (rd_en) begin
      rd_ofs_q <= ofs_mem[idx_q];
      rd_hnd_q <= hnd_mem[idx_q];
    end
  end

  assign out_idx = OIDX_W'(idx_q);

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q  <= {1'b0, rd_hnd_q, rd_ofs_q, out_idx, OCNT_W'(cnt_q), last_lvl_q,
                      last_fn_q};
      out_blast_q <= at_last;
      out_rlast_q <= at_last && (flush_b_q || !it_end_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_blast_q;
  assign m_axis_tlast  = out_rlast_q;

endmodule

### hw/rtl/dib_checker.sv
// Port checker for the draw instance batcher, bound to the top level.
`timescale 1ns / 1ps

module dib_checker
  import dib_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous word still in work");

  a_index_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == ((6'(m_axis_tdata[30:26]) + 6'd1) == m_axis_tdata[25:20])) &&
      (m_axis_tdata[25:20] != 6'd0))
    else $error("batch index and count disagree");

  a_run_in_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("run ends inside a batch");

endmodule

bind draw_instance_batcher dib_checker u_dib_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
